// ----- design/asp_pkg.sv -----
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants of the atlas shelf packer
// Beat layouts, result status codes, register indexes and the controller states.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Fixed field widths of the channels.
  localparam int RECT_W      = 13;  // rectangle width and height
  localparam int REG_W       = 13;  // atlas width and height registers
  localparam int OUT_COORD_W = 12;  // reported corner coordinates
  localparam int PLACE_IDX_W = 16;  // running placement number
  localparam int CFG_IDX_W   = 2;   // configuration register index

  // Coordinate width that the tokens carry.
  localparam int COORD_MAX_W = 16;

  // Defaults for the top level parameters.
  localparam int MAX_SHELVES_DEF = 32;
  localparam int COORD_BITS_DEF  = 13;

  localparam logic [REG_W-1:0] ATLAS_WIDTH_RST  = REG_W'(1024);
  localparam logic [REG_W-1:0] ATLAS_HEIGHT_RST = REG_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    STAT_SHELF = 2'd0,
    STAT_NEW   = 2'd1,
    STAT_FULL  = 2'd2
  } asp_status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } asp_state_t;

  typedef struct packed {
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
  } asp_in_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] place_x;
    logic [OUT_COORD_W-1:0] place_y;
    asp_status_t            status;
    logic [PLACE_IDX_W-1:0] placement_index;
  } asp_out_t;

  // Search token that walks down the row of shelf cells.
  typedef struct packed {
    logic                   valid;
    logic                   hit;
    logic [RECT_W-1:0]      w;
    logic [RECT_W-1:0]      h;
    logic [COORD_MAX_W-1:0] x;
    logic [COORD_MAX_W-1:0] y;
  } asp_tok_t;

  // Broadcast write that opens a new shelf.
  typedef struct packed {
    logic                   we;
    logic [COORD_MAX_W-1:0] top;
    logic [RECT_W-1:0]      tall;
    logic [RECT_W-1:0]      fill;
  } asp_wr_t;

endpackage

// ----- design/asp_cell.sv -----
// ----------------------------------------------------------------------------
// asp_cell: one shelf of the packer
// Holds a shelf's top, height and fill point, tests the passing token against
// it and hands the token on to the next cell through a register.
// ----------------------------------------------------------------------------
module asp_cell #(
  parameter int MAX_SHELVES = asp_pkg::MAX_SHELVES_DEF,
  parameter int COORD_BITS  = asp_pkg::COORD_BITS_DEF,
  parameter int IDX         = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(MAX_SHELVES+1)-1:0]      shelf_count,
  input  logic [asp_pkg::REG_W-1:0]             width_lim,
  input  asp_pkg::asp_wr_t                      wr,
  input  asp_pkg::asp_tok_t                     tok_i,
  output asp_pkg::asp_tok_t                     tok_o
);
  import asp_pkg::*;

  localparam int CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int BASE_W = (COORD_BITS > RECT_W) ? COORD_BITS : RECT_W;
  localparam int SUM_W = BASE_W + 1;

  logic [COORD_BITS-1:0] top_r, top_nxt;
  logic [COORD_BITS-1:0] tall_r, tall_nxt;
  logic [COORD_BITS-1:0] fill_r, fill_nxt;
  asp_tok_t              tok_r, tok_nxt;
  logic                  occupied;
  logic                  fits;
  logic [SUM_W-1:0]      fill_sum;

  assign occupied = CNT_W'(IDX) < shelf_count;
  assign fill_sum = SUM_W'(fill_r) + SUM_W'(tok_i.w);
  assign fits = tok_i.valid && !tok_i.hit && occupied &&
                (SUM_W'(tok_i.h) <= SUM_W'(tall_r)) &&
                (fill_sum <= SUM_W'(width_lim));

  always_comb begin
    tok_nxt  = tok_i;
    top_nxt  = top_r;
    tall_nxt = tall_r;
    fill_nxt = fill_r;
    if (fits) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.x   = COORD_MAX_W'(fill_r);
      tok_nxt.y   = COORD_MAX_W'(top_r);
      fill_nxt    = COORD_BITS'(fill_sum);
    end
    if (wr.we && (shelf_count == CNT_W'(IDX))) begin
      top_nxt  = COORD_BITS'(wr.top);
      tall_nxt = COORD_BITS'(wr.tall);
      fill_nxt = COORD_BITS'(wr.fill);
    end
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    tall_r <= tall_nxt;
    fill_r <= fill_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- design/atlas_shelf_packer_unit.sv -----
// ----------------------------------------------------------------------------
// atlas_shelf_packer_unit: shelf first-fit rectangle placement
// Places each rectangle on the first open shelf that is tall enough and has
// room across, or opens a new shelf below the used height, else reports full.
//
//   channel | ports                                | handshake
//   --------+--------------------------------------+---------------------------
//   input   | start, busy, in_data                 | beat when start && !busy
//   result  | out_valid, out_data                  | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_index/data | beat when valid && ready
//
// Each item is searched in full before the next is accepted. The search token
// steps through the row of shelf cells one cell per clock, registered in each
// cell; once it leaves the last cell the controller decides and updates the
// shelf table and counters, raises the result strobe and drops busy, so a new
// beat can be accepted in the cycle in which the result is shown.
// Reset is synchronous and active low; it empties the shelf table by clearing
// the shelf count, so no clearing pass is needed.
// The receiver cannot stall; busy drops on the same edge the result shows.
// ----------------------------------------------------------------------------
module atlas_shelf_packer_unit #(
  parameter int MAX_SHELVES = asp_pkg::MAX_SHELVES_DEF,
  parameter int COORD_BITS  = asp_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  asp_pkg::asp_in_t              in_data,
  output logic                          out_valid,
  output asp_pkg::asp_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [asp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asp_pkg::REG_W-1:0]     cfg_data
);
  import asp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SHELVES + 1);
  localparam int BASE_W = (COORD_BITS > RECT_W) ? COORD_BITS : RECT_W;
  localparam int SUM_W  = BASE_W + 1;

  asp_state_t             state_r, state_nxt;
  logic [REG_W-1:0]       atlas_w_r, atlas_h_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [COORD_BITS-1:0]  used_r, used_nxt;
  logic [PLACE_IDX_W-1:0] placed_r, placed_nxt;
  logic                   out_valid_r, out_valid_nxt;
  asp_out_t               out_data_r, out_data_nxt;
  asp_wr_t                wr;
  asp_tok_t               head;
  asp_tok_t               tok [MAX_SHELVES+1];
  asp_tok_t               tail;
  logic                   accept;
  logic [SUM_W-1:0]       height_sum;
  logic                   room;

  assign accept = start && (state_r == S_IDLE);

  // The token enters the first cell straight from the input beat.
  always_comb begin
    head       = '0;
    head.valid = accept;
    head.w     = in_data.rect_width;
    head.h     = in_data.rect_height;
  end

  assign tok[0] = head;

  for (genvar i = 0; i < MAX_SHELVES; i++) begin : g_cell
    asp_cell #(
      .MAX_SHELVES (MAX_SHELVES),
      .COORD_BITS  (COORD_BITS),
      .IDX         (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shelf_count (count_r),
      .width_lim   (atlas_w_r),
      .wr          (wr),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1])
    );
  end

  assign tail = tok[MAX_SHELVES];

  // A new shelf needs a free table slot, height left in the atlas and a
  // rectangle no wider than the atlas.
  assign height_sum = SUM_W'(used_r) + SUM_W'(tail.h);
  assign room = (count_r < CNT_W'(MAX_SHELVES)) &&
                (height_sum <= SUM_W'(atlas_h_r)) &&
                (tail.w <= atlas_w_r);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    placed_nxt    = placed_r;
    wr            = '0;
    wr.top        = COORD_MAX_W'(used_r);
    wr.tall       = tail.h;
    wr.fill       = tail.w;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          priority if (tail.hit) begin
            out_data_nxt.place_x         = OUT_COORD_W'(tail.x);
            out_data_nxt.place_y         = OUT_COORD_W'(tail.y);
            out_data_nxt.status          = STAT_SHELF;
            out_data_nxt.placement_index = placed_r;
            placed_nxt                   = placed_r + PLACE_IDX_W'(1);
          end else if (room) begin
            out_data_nxt.place_x         = '0;
            out_data_nxt.place_y         = OUT_COORD_W'(used_r);
            out_data_nxt.status          = STAT_NEW;
            out_data_nxt.placement_index = placed_r;
            placed_nxt                   = placed_r + PLACE_IDX_W'(1);
            wr.we                        = 1'b1;
            count_nxt                    = count_r + CNT_W'(1);
            used_nxt                     = COORD_BITS'(height_sum);
          end else begin
            // No room anywhere: report zeros and leave the shelf table and counters alone.
            out_data_nxt.place_x         = '0;
            out_data_nxt.place_y         = '0;
            out_data_nxt.status          = STAT_FULL;
            out_data_nxt.placement_index = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
      placed_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      placed_r    <= placed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= ATLAS_WIDTH_RST;
      atlas_h_r <= ATLAS_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ATLAS_WIDTH) begin
        atlas_w_r <= cfg_data;
      end
      if (cfg_index == REG_ATLAS_HEIGHT) begin
        atlas_h_r <= cfg_data;
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == S_SCAN);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/asp_checker.sv -----
// ----------------------------------------------------------------------------
// asp_checker: port-level checks for the atlas shelf packer
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module asp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input asp_pkg::asp_out_t out_data
);
  import asp_pkg::*;

  // An accepted beat makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // Busy ends exactly when the result strobe appears.
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result beat");

  // A result beat is never shown while the block is still busy.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // The strobe lasts one cycle.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A no-room result carries zero fields.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_FULL) |->
      (out_data.place_x == '0) && (out_data.place_y == '0) &&
      (out_data.placement_index == '0))
    else $error("no-room result with nonzero fields");

endmodule

bind atlas_shelf_packer_unit asp_checker u_asp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
